FILE: hdl/ray_triangle_intersect_unit_defines.svh
// Assertion macros used by the checker.
`ifndef RAY_TRIANGLE_INTERSECT_UNIT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define RTI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ray triangle unit: implication check failed");

// Next-cycle implication, checked during reset as well.
`define RTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ray triangle unit: next-cycle check failed");

`endif

FILE: hdl/rti_pkg.sv
package rti_pkg;

  // Field and register widths.
  localparam int COORD_WIDTH   = 21;
  localparam int FRAC_BITS     = 13;
  localparam int REG_WIDTH     = 63;
  localparam int MIN_WIDTH     = 20;
  localparam int DIST_WIDTH    = 31;
  localparam int CFG_IDX_WIDTH = 3;

  // Datapath widths: edge differences, 2x2 minors, determinant sums.
  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW2 = 2 * DW;
  localparam int MW  = 2 * DW + 1;
  localparam int PW  = DW + MW;
  localparam int EW  = PW + 2;
  localparam int RW  = EW + 1;
  // The wide minor operand is split into a low unsigned and a high signed half.
  localparam int MLO = MW / 2;
  localparam int MHI = MW - MLO;
  localparam int PLW = DW + MLO + 1;
  localparam int PHW = DW + MHI;
  // Hit point products.
  localparam int HPW = DIST_WIDTH + 1 + COORD_WIDTH;
  localparam int STW = HPW - FRAC_BITS;
  localparam int VW  = STW + 1;
  localparam int DIV_STAGES = DIST_WIDTH;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_VERTEX_A = 0,
    REG_VERTEX_B = 1,
    REG_VERTEX_C = 2,
    REG_MIN_DIST = 3
  } cfg_reg_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // Sideband that travels with each ray down the pipeline.
  typedef struct packed {
    logic                            valid;
    logic                            miss;
    logic [2:0][COORD_WIDTH-1:0]     orig;
    logic [2:0][COORD_WIDTH-1:0]     dir;
  } rti_side_t;

  // Coordinate k of a packed vertex; bits beyond the register read as zero.
  function automatic coord_t vertex_coord(input logic [REG_WIDTH-1:0] packed_v, input int k);
    logic [REG_WIDTH:0] wide_v;
    wide_v = {1'b0, packed_v} >> (k * COORD_WIDTH);
    return coord_t'(wide_v[COORD_WIDTH-1:0]);
  endfunction

endpackage

FILE: hdl/ray_triangle_intersect_unit.sv
// Ray/triangle test by Cramer's rule, fully pipelined over 41 register stages.
// A ray is taken in every cycle (busy stays low); out_valid rises once for each
// accepted ray, one result beat per ray, in order.
// The 31-stage restoring divider that forms the distance takes most of the stages.
// Synchronous active-low reset clears all valid bits and loads the registers
// with vertices at zero and min_distance at one.
module ray_triangle_intersect_unit
  import rti_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  logic signed [COORD_WIDTH-1:0] in_direction_x,
  input  logic signed [COORD_WIDTH-1:0] in_direction_y,
  input  logic signed [COORD_WIDTH-1:0] in_direction_z,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
  input  logic [REG_WIDTH-1:0]          cfg_wdata,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [DIST_WIDTH-1:0]         out_distance,
  output logic signed [COORD_WIDTH-1:0] out_hit_point_x,
  output logic signed [COORD_WIDTH-1:0] out_hit_point_y,
  output logic signed [COORD_WIDTH-1:0] out_hit_point_z,
  output logic                          out_saturated
);

  localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};
  localparam logic signed [VW-1:0]  PT_MAX   = (VW'(1) <<< (COORD_WIDTH - 1)) - VW'(1);
  localparam logic signed [VW-1:0]  PT_MIN   = -PT_MAX - VW'(1);

  // Configuration registers.
  logic [REG_WIDTH-1:0] vertex_a_r, vertex_b_r, vertex_c_r;
  logic [MIN_WIDTH-1:0] min_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_a_r <= '0;
      vertex_b_r <= '0;
      vertex_c_r <= '0;
      min_dist_r <= MIN_WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERTEX_A: vertex_a_r <= cfg_wdata;
        REG_VERTEX_B: vertex_b_r <= cfg_wdata;
        REG_VERTEX_C: vertex_c_r <= cfg_wdata;
        REG_MIN_DIST: min_dist_r <= cfg_wdata[MIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Every cycle takes a beat.
  assign busy = 1'b0;

  // Stage 1: edge columns and right-hand side.
  rti_side_t             side_nxt, side1_r;
  logic signed [DW-1:0]  col1_r [3];
  logic signed [DW-1:0]  col2_r [3];
  logic signed [DW-1:0]  rhs_r  [3];
  logic signed [DW-1:0]  dirw   [3];
  coord_t                orig_in [3];

  assign orig_in[0] = in_origin_x;
  assign orig_in[1] = in_origin_y;
  assign orig_in[2] = in_origin_z;

  always_comb begin
    side_nxt.valid  = start;
    side_nxt.miss   = 1'b0;
    side_nxt.orig   = {in_origin_z, in_origin_y, in_origin_x};
    side_nxt.dir    = {in_direction_z, in_direction_y, in_direction_x};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.valid <= 1'b0;
    end else begin
      side1_r <= side_nxt;
    end
    for (int k = 0; k < 3; k++) begin
      col1_r[k] <= DW'(vertex_coord(vertex_a_r, k)) - DW'(vertex_coord(vertex_b_r, k));
      col2_r[k] <= DW'(vertex_coord(vertex_a_r, k)) - DW'(vertex_coord(vertex_c_r, k));
      rhs_r[k]  <= DW'(vertex_coord(vertex_a_r, k)) - DW'(orig_in[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dirw[k] = DW'(signed'(side1_r.dir[k]));
    end
  end

  // Stage 2: products for the 2x2 minors of the y and z rows.
  rti_side_t             side2_r;
  logic signed [PW2-1:0] prod2_r [12];
  logic signed [DW-1:0]  x0_2_r  [3];
  logic signed [DW-1:0]  ma [12];
  logic signed [DW-1:0]  mb [12];

  always_comb begin
    ma[0]  = col2_r[1]; mb[0]  = dirw[2];
    ma[1]  = dirw[1];   mb[1]  = col2_r[2];
    ma[2]  = rhs_r[1];  mb[2]  = dirw[2];
    ma[3]  = dirw[1];   mb[3]  = rhs_r[2];
    ma[4]  = col2_r[1]; mb[4]  = rhs_r[2];
    ma[5]  = rhs_r[1];  mb[5]  = col2_r[2];
    ma[6]  = dirw[1];   mb[6]  = col1_r[2];
    ma[7]  = col1_r[1]; mb[7]  = dirw[2];
    ma[8]  = col1_r[1]; mb[8]  = col2_r[2];
    ma[9]  = col2_r[1]; mb[9]  = col1_r[2];
    ma[10] = col1_r[1]; mb[10] = rhs_r[2];
    ma[11] = rhs_r[1];  mb[11] = col1_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r.valid <= 1'b0;
    end else begin
      side2_r <= side1_r;
    end
    for (int i = 0; i < 12; i++) begin
      prod2_r[i] <= PW2'(ma[i]) * PW2'(mb[i]);
    end
    x0_2_r[0] <= col1_r[0];
    x0_2_r[1] <= col2_r[0];
    x0_2_r[2] <= rhs_r[0];
  end

  // Stage 3: minors m, n, p, q, s, r.
  rti_side_t            side3_r;
  logic signed [MW-1:0] minor_r [6];
  logic signed [DW-1:0] x0_3_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side3_r.valid <= 1'b0;
    end else begin
      side3_r <= side2_r;
    end
    for (int i = 0; i < 6; i++) begin
      minor_r[i] <= MW'(prod2_r[2*i]) - MW'(prod2_r[2*i+1]);
    end
    x0_3_r <= x0_2_r;
  end

  // Stage 4: x-row times minor, as two partial products each.
  localparam int MI_M = 0, MI_N = 1, MI_P = 2, MI_Q = 3, MI_S = 4, MI_R = 5;
  rti_side_t             side4_r;
  logic signed [PLW-1:0] plo_r [12];
  logic signed [PHW-1:0] phi_r [12];
  logic signed [DW-1:0]  xa [12];
  logic signed [MW-1:0]  xb [12];
  logic signed [DW-1:0]  dir0_3;

  assign dir0_3 = DW'(signed'(side3_r.dir[0]));

  always_comb begin
    // det terms
    xa[0]  = x0_3_r[0]; xb[0]  = minor_r[MI_M];
    xa[1]  = x0_3_r[1]; xb[1]  = minor_r[MI_Q];
    xa[2]  = dir0_3;    xb[2]  = minor_r[MI_S];
    // beta numerator terms
    xa[3]  = x0_3_r[2]; xb[3]  = minor_r[MI_M];
    xa[4]  = x0_3_r[1]; xb[4]  = minor_r[MI_N];
    xa[5]  = dir0_3;    xb[5]  = minor_r[MI_P];
    // gamma numerator terms
    xa[6]  = x0_3_r[0]; xb[6]  = minor_r[MI_N];
    xa[7]  = x0_3_r[2]; xb[7]  = minor_r[MI_Q];
    xa[8]  = dir0_3;    xb[8]  = minor_r[MI_R];
    // distance numerator terms
    xa[9]  = x0_3_r[0]; xb[9]  = minor_r[MI_P];
    xa[10] = x0_3_r[1]; xb[10] = minor_r[MI_R];
    xa[11] = x0_3_r[2]; xb[11] = minor_r[MI_S];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side4_r.valid <= 1'b0;
    end else begin
      side4_r <= side3_r;
    end
    for (int i = 0; i < 12; i++) begin
      plo_r[i] <= PLW'(xa[i]) * PLW'(signed'({1'b0, xb[i][MLO-1:0]}));
      phi_r[i] <= PHW'(xa[i]) * PHW'(signed'(xb[i][MW-1:MLO]));
    end
  end

  // Stage 5: recombine the halves.
  rti_side_t            side5_r;
  logic signed [PW-1:0] prod5_r [12];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side5_r.valid <= 1'b0;
    end else begin
      side5_r <= side4_r;
    end
    for (int i = 0; i < 12; i++) begin
      prod5_r[i] <= (PW'(phi_r[i]) <<< MLO) + PW'(plo_r[i]);
    end
  end

  // Stage 6: determinant and the three numerators.
  rti_side_t            side6_r;
  logic signed [EW-1:0] det6_r, e1_6_r, e2_6_r, e3_6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side6_r.valid <= 1'b0;
    end else begin
      side6_r <= side5_r;
    end
    det6_r <= EW'(prod5_r[0]) + EW'(prod5_r[1]) + EW'(prod5_r[2]);
    e1_6_r <= EW'(prod5_r[3]) - EW'(prod5_r[4]) - EW'(prod5_r[5]);
    e2_6_r <= EW'(prod5_r[6]) + EW'(prod5_r[7]) + EW'(prod5_r[8]);
    e3_6_r <= EW'(prod5_r[9]) - EW'(prod5_r[10]) + EW'(prod5_r[11]);
  end

  // Stage 7: make the determinant positive; a zero determinant is a miss.
  rti_side_t            side7_nxt, side7_r;
  logic signed [EW-1:0] det7_r, e1_7_r, e2_7_r, e3_7_r;
  logic                 det_neg;

  assign det_neg = det6_r[EW-1];

  always_comb begin
    side7_nxt      = side6_r;
    side7_nxt.miss = side6_r.miss | (det6_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side7_r.valid <= 1'b0;
    end else begin
      side7_r <= side7_nxt;
    end
    det7_r <= det_neg ? -det6_r : det6_r;
    e1_7_r <= det_neg ? -e1_6_r : e1_6_r;
    e2_7_r <= det_neg ? -e2_6_r : e2_6_r;
    e3_7_r <= det_neg ? -e3_6_r : e3_6_r;
  end

  // Stage 8: barycentric and sign tests, divider setup.
  rti_side_t              side8_nxt, side8_r;
  logic [EW-1:0]          det8_r;
  logic [RW-1:0]          rem8_r;
  logic [DIST_WIDTH-1:0]  nb8_r;
  logic                   ovf8_r;
  logic signed [EW:0]     bg_sum;
  logic                   tri_miss;
  logic [RW-1:0]          rem_init;
  logic signed [EW-1:0]   e3_shl;

  always_comb begin
    bg_sum   = (EW+1)'(e1_7_r) + (EW+1)'(e2_7_r);
    tri_miss = e1_7_r[EW-1] | e2_7_r[EW-1] | e3_7_r[EW-1]
             | ((EW+1)'(det7_r) < bg_sum);
    rem_init = RW'(e3_7_r >>> (DIST_WIDTH - FRAC_BITS));
    e3_shl   = e3_7_r <<< FRAC_BITS;
    side8_nxt      = side7_r;
    side8_nxt.miss = side7_r.miss | tri_miss;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side8_r.valid <= 1'b0;
    end else begin
      side8_r <= side8_nxt;
    end
    det8_r <= det7_r;
    rem8_r <= rem_init;
    nb8_r  <= e3_shl[DIST_WIDTH-1:0];
    ovf8_r <= rem_init >= {1'b0, det7_r};
  end

  // Distance quotient.
  rti_side_t             side_dv;
  logic [DIST_WIDTH-1:0] quot_dv;
  logic                  ovf_dv;

  rti_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_in  (side8_r),
    .det_in   (det8_r),
    .rem_in   (rem8_r),
    .nbits_in (nb8_r),
    .ovf_in   (ovf8_r),
    .side_out (side_dv),
    .quot_out (quot_dv),
    .ovf_out  (ovf_dv)
  );

  // Minimum distance test, clipping and the distance-times-direction products.
  rti_side_t             side9_nxt, side9_r;
  logic [DIST_WIDTH-1:0] dist9_r;
  logic                  dsat9_r;
  logic signed [HPW-1:0] hp9_r [3];
  logic [DIST_WIDTH-1:0] dist_c;
  logic                  near_miss;

  always_comb begin
    dist_c    = ovf_dv ? DIST_MAX : quot_dv;
    near_miss = !ovf_dv && (quot_dv < DIST_WIDTH'(min_dist_r));
    side9_nxt      = side_dv;
    side9_nxt.miss = side_dv.miss | near_miss;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side9_r.valid <= 1'b0;
    end else begin
      side9_r <= side9_nxt;
    end
    dist9_r <= dist_c;
    dsat9_r <= ovf_dv;
    for (int k = 0; k < 3; k++) begin
      hp9_r[k] <= HPW'(signed'({1'b0, dist_c})) * HPW'(signed'(side_dv.dir[k]));
    end
  end

  // Output stage: hit point with saturation; a miss gives all zeros.
  logic signed [VW-1:0]          pt_sum [3];
  logic signed [COORD_WIDTH-1:0] pt_clip [3];
  logic [2:0]                    pt_sat;
  logic                          out_valid_r, out_hit_r, out_sat_r;
  logic [DIST_WIDTH-1:0]         out_dist_r;
  logic signed [COORD_WIDTH-1:0] out_pt_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pt_sum[k] = VW'(signed'(side9_r.orig[k])) + VW'(signed'(hp9_r[k][HPW-1:FRAC_BITS]));
      pt_sat[k] = 1'b0;
      priority if (pt_sum[k] > PT_MAX) begin
        pt_clip[k] = PT_MAX[COORD_WIDTH-1:0];
        pt_sat[k]  = 1'b1;
      end else if (pt_sum[k] < PT_MIN) begin
        pt_clip[k] = PT_MIN[COORD_WIDTH-1:0];
        pt_sat[k]  = 1'b1;
      end else begin
        pt_clip[k] = pt_sum[k][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= side9_r.valid;
    end
    out_hit_r  <= !side9_r.miss;
    out_dist_r <= side9_r.miss ? '0 : dist9_r;
    out_sat_r  <= !side9_r.miss && (dsat9_r || (pt_sat != '0));
    for (int k = 0; k < 3; k++) begin
      out_pt_r[k] <= side9_r.miss ? '0 : pt_clip[k];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_distance    = out_dist_r;
  assign out_saturated   = out_sat_r;
  assign out_hit_point_x = out_pt_r[0];
  assign out_hit_point_y = out_pt_r[1];
  assign out_hit_point_z = out_pt_r[2];

endmodule

FILE: hdl/rti_divider.sv
module rti_divider
  import rti_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  rti_side_t             side_in,
  input  logic [EW-1:0]         det_in,
  input  logic [RW-1:0]         rem_in,
  input  logic [DIST_WIDTH-1:0] nbits_in,
  input  logic                  ovf_in,
  output rti_side_t             side_out,
  output logic [DIST_WIDTH-1:0] quot_out,
  output logic                  ovf_out
);

  rti_side_t             side_r  [DIV_STAGES];
  logic [EW-1:0]         det_r   [DIV_STAGES];
  logic [RW-1:0]         rem_r   [DIV_STAGES];
  logic [DIST_WIDTH-1:0] nb_r    [DIV_STAGES];
  logic [DIST_WIDTH-1:0] quot_r  [DIV_STAGES];
  logic                  ovf_r   [DIV_STAGES];

  // One restoring step per stage: bring down a bit, subtract if it fits.
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
    rti_side_t             side_p;
    logic [EW-1:0]         det_p;
    logic [RW-1:0]         rem_p;
    logic [DIST_WIDTH-1:0] nb_p;
    logic [DIST_WIDTH-1:0] quot_p;
    logic                  ovf_p;
    logic [RW-1:0]         trial;
    logic                  fits;
    logic [RW-1:0]         rem_nxt;
    logic [DIST_WIDTH-1:0] quot_nxt;

    if (j == 0) begin : g_first
      assign side_p = side_in;
      assign det_p  = det_in;
      assign rem_p  = rem_in;
      assign nb_p   = nbits_in;
      assign quot_p = '0;
      assign ovf_p  = ovf_in;
    end else begin : g_next
      assign side_p = side_r[j-1];
      assign det_p  = det_r[j-1];
      assign rem_p  = rem_r[j-1];
      assign nb_p   = nb_r[j-1];
      assign quot_p = quot_r[j-1];
      assign ovf_p  = ovf_r[j-1];
    end

    always_comb begin
      trial    = {rem_p[RW-2:0], nb_p[DIST_WIDTH-1]};
      fits     = trial >= {1'b0, det_p};
      rem_nxt  = fits ? trial - {1'b0, det_p} : trial;
      quot_nxt = {quot_p[DIST_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[j].valid <= 1'b0;
      end else begin
        side_r[j] <= side_p;
      end
      det_r[j]  <= det_p;
      rem_r[j]  <= rem_nxt;
      nb_r[j]   <= nb_p << 1;
      quot_r[j] <= quot_nxt;
      ovf_r[j]  <= ovf_p;
    end
  end

  assign side_out = side_r[DIV_STAGES-1];
  assign quot_out = quot_r[DIV_STAGES-1];
  assign ovf_out  = ovf_r[DIV_STAGES-1];

endmodule

FILE: hdl/rti_checker.sv
`include "ray_triangle_intersect_unit_defines.svh"

module rti_checker
  import rti_pkg::*;
(
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] in_origin_x,
  input logic signed [COORD_WIDTH-1:0] in_origin_y,
  input logic signed [COORD_WIDTH-1:0] in_origin_z,
  input logic signed [COORD_WIDTH-1:0] in_direction_x,
  input logic signed [COORD_WIDTH-1:0] in_direction_y,
  input logic signed [COORD_WIDTH-1:0] in_direction_z,
  input logic                          cfg_we,
  input logic [CFG_IDX_WIDTH-1:0]      cfg_index,
  input logic [REG_WIDTH-1:0]          cfg_wdata,
  input logic                          out_valid,
  input logic                          out_hit,
  input logic [DIST_WIDTH-1:0]         out_distance,
  input logic signed [COORD_WIDTH-1:0] out_hit_point_x,
  input logic signed [COORD_WIDTH-1:0] out_hit_point_y,
  input logic signed [COORD_WIDTH-1:0] out_hit_point_z,
  input logic                          out_saturated
);

  localparam logic [COORD_WIDTH-1:0] RAIL_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] RAIL_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic miss_fields_zero;
  logic pt_on_rail;

  assign miss_fields_zero = out_distance == '0 && out_hit_point_x == '0
                          && out_hit_point_y == '0 && out_hit_point_z == '0
                          && !out_saturated;
  assign pt_on_rail = out_hit_point_x == RAIL_HI || out_hit_point_x == RAIL_LO
                    || out_hit_point_y == RAIL_HI || out_hit_point_y == RAIL_LO
                    || out_hit_point_z == RAIL_HI || out_hit_point_z == RAIL_LO;

  // The pipeline never refuses a ray.
  `RTI_ASSERT_IMP(a_never_busy, 1'b1, !busy)

  // A missed ray reports every field as zero.
  `RTI_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, miss_fields_zero)

  // A clip with the distance in range must come from a hit point pinned at a rail.
  `RTI_ASSERT_IMP(a_dist_clip, out_valid && out_hit && out_distance != '1 && out_saturated, pt_on_rail)

  // Reset flushes the pipeline: no result beat in the cycle after reset.
  `RTI_ASSERT_NEXT(a_reset_flush, !rst_n, !out_valid)

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rti_pkg::*;

  localparam int LATENCY = 41;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 10;
  localparam int RAYS_PER_PHASE = 75;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 3'd5;
  localparam longint DIST_SAT = 64'h7FFF_FFFF;
  localparam longint ONE = 64'd1 << FRAC_BITS;

  typedef struct {
    logic                   hit;
    logic [DIST_WIDTH-1:0]  distance;
    coord_t                 px;
    coord_t                 py;
    coord_t                 pz;
    logic                   sat;
  } hit_result_t;

  typedef struct {
    int          phase;
    coord_t      ox, oy, oz, dx, dy, dz;
    bit          known;
    hit_result_t res;
  } ray_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  coord_t in_origin_x, in_origin_y, in_origin_z;
  coord_t in_direction_x, in_direction_y, in_direction_z;
  logic cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [REG_WIDTH-1:0] cfg_wdata;
  logic out_valid, out_hit, out_saturated;
  logic [DIST_WIDTH-1:0] out_distance;
  coord_t out_hit_point_x, out_hit_point_y, out_hit_point_z;

  // Shadow copy of the triangle registers.
  logic [REG_WIDTH-1:0] tri_a, tri_b, tri_c;
  logic [MIN_WIDTH-1:0] tri_min;

  hit_result_t pending_hits[$];
  int errors = 0;
  int n_hits = 0;
  int n_sat = 0;
  int n_rays = 0;
  int cycles = 0;
  bit quiet = 0;

  ray_triangle_intersect_unit DUT (.*);

  // Clock.
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Signed coordinate k of a packed vertex, widened for exact arithmetic.
  function automatic logic signed [127:0] vcoord(logic [REG_WIDTH-1:0] v, int k);
    coord_t c;
    c = v[k*COORD_WIDTH +: COORD_WIDTH];
    return c;
  endfunction

  // Cramer's rule on the shadow triangle, exact in 128 bits.
  function automatic hit_result_t intersect_ray(coord_t ox, coord_t oy, coord_t oz,
                                                coord_t dx, coord_t dy, coord_t dz);
    logic signed [127:0] c1[3], c2[3], dr[3], rh[3];
    logic signed [127:0] m, n, p, q, s, r, det, e1, e2, e3;
    logic [127:0] tq;
    longint o[3], d[3], t_dist, v;
    bit sat;
    hit_result_t res;
    res = '{default: 0};
    o[0] = ox; o[1] = oy; o[2] = oz;
    d[0] = dx; d[1] = dy; d[2] = dz;
    for (int k = 0; k < 3; k++) begin
      c1[k] = vcoord(tri_a, k) - vcoord(tri_b, k);
      c2[k] = vcoord(tri_a, k) - vcoord(tri_c, k);
      dr[k] = d[k];
      rh[k] = vcoord(tri_a, k) - o[k];
    end
    m = c2[1] * dr[2] - dr[1] * c2[2];
    n = rh[1] * dr[2] - dr[1] * rh[2];
    p = c2[1] * rh[2] - rh[1] * c2[2];
    q = dr[1] * c1[2] - c1[1] * dr[2];
    s = c1[1] * c2[2] - c2[1] * c1[2];
    r = c1[1] * rh[2] - rh[1] * c1[2];
    det = c1[0] * m + c2[0] * q + dr[0] * s;
    e1 = rh[0] * m - c2[0] * n - dr[0] * p;
    e2 = c1[0] * n + rh[0] * q + dr[0] * r;
    e3 = c1[0] * p - c2[0] * r + rh[0] * s;
    if (det == 0) return res;
    if (det < 0) begin
      det = -det; e1 = -e1; e2 = -e2; e3 = -e3;
    end
    if (e1 < 0 || e2 < 0 || det < e1 + e2 || e3 < 0) return res;
    tq = (128'(e3) << FRAC_BITS) / 128'(det);
    if (tq < 128'(tri_min)) return res;
    sat = 0;
    if (tq > 128'(DIST_SAT)) begin
      t_dist = DIST_SAT;
      sat = 1;
    end else begin
      t_dist = longint'(tq[62:0]);
    end
    // Hit point: origin plus floor(distance * direction).
    for (int k = 0; k < 3; k++) begin
      v = o[k] + ((t_dist * d[k]) >>> FRAC_BITS);
      if (v > (64'sd1 << (COORD_WIDTH - 1)) - 1) begin
        v = (64'sd1 << (COORD_WIDTH - 1)) - 1;
        sat = 1;
      end
      if (v < -(64'sd1 << (COORD_WIDTH - 1))) begin
        v = -(64'sd1 << (COORD_WIDTH - 1));
        sat = 1;
      end
      if (k == 0) res.px = coord_t'(v);
      else if (k == 1) res.py = coord_t'(v);
      else res.pz = coord_t'(v);
    end
    res.hit = 1;
    res.distance = t_dist[DIST_WIDTH-1:0];
    res.sat = sat;
    return res;
  endfunction

  // Result checker: every beat is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_hits.size() == 0) begin
        $error("result beat with no ray outstanding");
        errors++;
      end else begin
        hit_result_t e;
        e = pending_hits.pop_front();
        if (out_hit !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, out_hit); errors++;
        end
        if (out_distance !== e.distance) begin
          $error("distance: expected %0d, got %0d", e.distance, out_distance); errors++;
        end
        if (out_hit_point_x !== e.px) begin
          $error("hit_point_x: expected %0d, got %0d", e.px, out_hit_point_x); errors++;
        end
        if (out_hit_point_y !== e.py) begin
          $error("hit_point_y: expected %0d, got %0d", e.py, out_hit_point_y); errors++;
        end
        if (out_hit_point_z !== e.pz) begin
          $error("hit_point_z: expected %0d, got %0d", e.pz, out_hit_point_z); errors++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated: expected %0d, got %0d", e.sat, out_saturated); errors++;
        end
        if (e.hit) n_hits++;
        if (e.sat) n_sat++;
      end
    end
  end

  // One register write; the caller lowers the write enable after its last write.
  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [REG_WIDTH-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_VERTEX_A: tri_a = val;
      REG_VERTEX_B: tri_b = val;
      REG_VERTEX_C: tri_c = val;
      REG_MIN_DIST: tri_min = val[MIN_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic load_triangle(logic [REG_WIDTH-1:0] a, logic [REG_WIDTH-1:0] b,
                               logic [REG_WIDTH-1:0] c, logic [MIN_WIDTH-1:0] md);
    write_reg(REG_VERTEX_A, a);
    write_reg(REG_VERTEX_B, b);
    write_reg(REG_VERTEX_C, c);
    write_reg(REG_MIN_DIST, {{(REG_WIDTH-MIN_WIDTH){1'b0}}, md});
    // A write to an unused index must leave the triangle alone.
    write_reg(REG_SPARE, REG_WIDTH'({$urandom, $urandom}));
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Let the pipeline empty before the triangle is touched.
  task automatic drain_pipe();
    start <= 0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Present one ray beat and record what it should produce.
  task automatic send_ray(coord_t ox, coord_t oy, coord_t oz, coord_t dx, coord_t dy,
                          coord_t dz, bit known, hit_result_t fixed);
    start <= 1;
    in_origin_x <= ox; in_origin_y <= oy; in_origin_z <= oz;
    in_direction_x <= dx; in_direction_y <= dy; in_direction_z <= dz;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_hits.push_back(known ? fixed : intersect_ray(ox, oy, oz, dx, dy, dz));
    n_rays++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic logic [REG_WIDTH-1:0] pack_vertex(longint x, longint y, longint z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  function automatic longint rand_span(int bits);
    return longint'($urandom_range(0, 2 ** (bits + 1))) - (longint'(1) << bits);
  endfunction

  localparam longint FOUR = 4 * ONE;
  localparam longint CMAX = (1 << (COORD_WIDTH - 1)) - 1;
  localparam longint CMIN = -(1 << (COORD_WIDTH - 1));

  // Directed rays; phase selects the triangle in force.
  ray_row_t directed[] = '{
    '{0, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1, '{default: 0}},
    '{0, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1, '{default: 0}},
    '{0, 0, 0, 0, 0, 0, ONE, 1, '{default: 0}},
    '{1, ONE, ONE, 0, 0, 0, ONE, 0, '{default: 0}},
    '{1, 0, ONE, 0, 0, 0, ONE, 0, '{default: 0}},
    '{1, ONE, 0, 0, 0, 0, ONE, 0, '{default: 0}},
    '{1, 2 * ONE, 2 * ONE, 0, 0, 0, ONE, 0, '{default: 0}},
    '{1, -1, ONE, 0, 0, 0, ONE, 0, '{default: 0}},
    '{1, 2 * ONE, 2 * ONE + 1, 0, 0, 0, ONE, 0, '{default: 0}},
    '{1, ONE, ONE, 0, 0, 0, -ONE, 0, '{default: 0}},
    '{1, ONE, ONE, 0, ONE, 0, 0, 0, '{default: 0}},
    '{1, ONE, ONE, FOUR, 0, 0, ONE, 0, '{default: 0}},
    '{1, ONE, ONE, 0, 1, 1, 1, 0, '{default: 0}},
    '{2, ONE, ONE, 0, 0, 0, ONE, 0, '{default: 0}},
    '{2, ONE, ONE, 0, 0, 0, 1, 0, '{default: 0}},
    '{3, 1, 1, CMIN, 0, 0, 1, 0, '{default: 0}},
    '{3, 1, 1, CMIN, CMAX, CMAX, 1, 0, '{default: 0}},
    '{3, 1, 1, CMIN, CMIN, CMIN, 1, 0, '{default: 0}},
    '{3, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0, '{default: 0}},
    '{3, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, '{default: 0}}
  };

  initial begin
    int phase;
    longint ax, ay, az, bx, by, bz, cx, cy, cz, bw, gw, k, tx, ty, tz, dx, dy, dz;
    rst_n = 0;
    start = 0;
    cfg_we = 0;
    cfg_index = REG_VERTEX_A;
    cfg_wdata = '0;
    in_origin_x = 0; in_origin_y = 0; in_origin_z = 0;
    in_direction_x = 0; in_direction_y = 0; in_direction_z = 0;
    tri_a = '0; tri_b = '0; tri_c = '0; tri_min = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: reset triangle first, then fixed triangles.
    phase = 0;
    foreach (directed[i]) begin
      if (directed[i].phase != phase) begin
        phase = directed[i].phase;
        drain_pipe();
        case (phase)
          1: load_triangle(pack_vertex(0, 0, FOUR), pack_vertex(FOUR, 0, FOUR),
                           pack_vertex(0, FOUR, FOUR), MIN_WIDTH'(1));
          2: load_triangle(tri_a, tri_b, tri_c, {MIN_WIDTH{1'b1}});
          default: load_triangle(pack_vertex(0, 0, CMAX), pack_vertex(CMAX, 0, CMAX),
                                 pack_vertex(0, CMAX, CMAX), '0);
        endcase
      end
      send_ray(directed[i].ox, directed[i].oy, directed[i].oz, directed[i].dx,
               directed[i].dy, directed[i].dz, directed[i].known, directed[i].res);
    end

    // Random part: each phase draws a triangle, then mostly aimed rays (only random rays when ph % 4 == 3).
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_pipe();
      if (ph >= RANDOM_PHASES - 2) quiet = 1;
      ax = rand_span(17); ay = rand_span(17); az = rand_span(17);
      bx = rand_span(17); by = rand_span(17); bz = rand_span(17);
      cx = rand_span(17); cy = rand_span(17); cz = rand_span(17);
      case (ph % 4)
        0: load_triangle(pack_vertex(ax, ay, az), pack_vertex(bx, by, bz),
                         pack_vertex(cx, cy, cz), '0);
        1: load_triangle(pack_vertex(ax, ay, az), pack_vertex(bx, by, bz),
                         pack_vertex(cx, cy, cz), MIN_WIDTH'($urandom_range(0, 8 * ONE)));
        2: load_triangle(pack_vertex(ax, ay, az), pack_vertex(bx, by, bz),
                         pack_vertex(cx, cy, cz), MIN_WIDTH'(1));
        default: load_triangle(REG_WIDTH'({$urandom, $urandom}),
                               REG_WIDTH'({$urandom, $urandom}),
                               REG_WIDTH'({$urandom, $urandom}), MIN_WIDTH'($urandom));
      endcase
      for (int i = 0; i < RAYS_PER_PHASE; i++) begin
        if ($urandom_range(0, 9) < 7 && ph % 4 != 3) begin
          // Aim at a point inside or just around the triangle.
          bw = $urandom_range(0, 280);
          gw = $urandom_range(0, 280 - bw);
          tx = ax + ((bw * (bx - ax) + gw * (cx - ax)) >>> 8);
          ty = ay + ((bw * (by - ay) + gw * (cy - ay)) >>> 8);
          tz = az + ((bw * (bz - az) + gw * (cz - az)) >>> 8);
          dx = rand_span(14); dy = rand_span(14); dz = rand_span(14);
          k = $urandom_range(0, 8);
          send_ray(coord_t'(tx - k * dx), coord_t'(ty - k * dy), coord_t'(tz - k * dz),
                   coord_t'(dx), coord_t'(dy), coord_t'(dz), 0, '{default: 0});
        end else begin
          send_ray(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                   coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                   0, '{default: 0});
        end
      end
    end

    drain_pipe();
    $display("Sent %0d rays over %0d triangle settings: %0d hits, %0d saturated.",
             n_rays, RANDOM_PHASES + 4, n_hits, n_sat);
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
